// ===== hw/rtl/ptt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

   // defaults for the top-level parameters
   localparam int NUM_TIMERS_DEF = 16;
   localparam int MAX_FIRES_DEF  = 64;

   // fixed field widths
   localparam int TIME_W      = 32;
   localparam int ID_W        = 8;
   localparam int BUDGET_W    = 7;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_SET   = 2'd1,
      REQ_KILL  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_FIRE = 2'd0,
      KIND_ACK  = 2'd1,
      KIND_ERR  = 2'd2
   } rsp_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_LOOP,
      ST_FLUSH
   } state_type;

   // one timer entry as held in the table memory
   typedef struct packed {
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] due;
      logic              notify;
   } ptt_entry_type;

   // controller to table memory
   typedef struct packed {
      logic          wr_en;
      logic          set_valid;
      logic          kill_en;
      logic          clear_en;
      logic [ID_W-1:0] wr_addr;
      ptt_entry_type wr_data;
      logic          rd_en;
      logic [ID_W-1:0] rd_addr;
   } ptt_mem_req_type;

   // one result item
   typedef struct packed {
      rsp_kind_type      kind;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] elapsed;
      logic              last;
   } ptt_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/periodic_timer_table.sv =====
// Set, kill: one result item, via the pending slot and the output register; clear gives none.
// Tick: walks the timers in order and consumes at most MAX_FIRES periods in all; each timer
// costs a table read, a load from the registered read port and, if active, a write-back.
// One item is in work at a time; results drain through an output register.
// Reset is synchronous and active high; it marks every table entry invalid (inactive)
// at once, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_table #(
   parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF,
   parameter int MAX_FIRES  = ptt_pkg::MAX_FIRES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: timer_id[7:0], period_ms[39:8], notify_enable[40], now_ms[72:41], zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ptt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [ptt_pkg::REQ_TUSER_W-1:0] req_tuser,
   // tdata: fired_id[7:0], elapsed_ms[39:8]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ptt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: kind[1:0]
   output logic [ptt_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import ptt_pkg::*;

   ptt_mem_req_type mem_req;
   ptt_entry_type   rd_data;
   logic            rd_valid;

   ptt_ctrl #(
      .NUM_TIMERS (NUM_TIMERS),
      .MAX_FIRES  (MAX_FIRES)
   ) u_ptt_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .rd_valid   (rd_valid)
   );

   ptt_mem #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_ptt_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .rd_data  (rd_data),
      .rd_valid (rd_valid)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ptt_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptt_mem #(
   parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ptt_pkg::ptt_mem_req_type mem_req,
   output ptt_pkg::ptt_entry_type  rd_data,
   output logic                    rd_valid
);
   import ptt_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   ptt_entry_type           store_ff [NUM_TIMERS];
   ptt_entry_type           rd_data_ff;
   logic                    rd_valid_ff;
   logic [NUM_TIMERS-1:0]   valid_ff;
   logic [NUM_TIMERS-1:0]   valid_in;
   logic [IDX_W-1:0]        wr_idx;
   logic [IDX_W-1:0]        rd_idx;

   assign wr_idx = mem_req.wr_addr[IDX_W-1:0];
   assign rd_idx = mem_req.rd_addr[IDX_W-1:0];

   // table storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[wr_idx] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= store_ff[rd_idx];
      end
   end

   // per-entry valid bits; an invalid entry reads as an inactive timer
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.clear_en) begin
         valid_in = '0;
      end else if (mem_req.set_valid) begin
         valid_in[wr_idx] = 1'b1;
      end else if (mem_req.kill_en) begin
         valid_in[wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ptt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptt_ctrl #(
   parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF,
   parameter int MAX_FIRES  = ptt_pkg::MAX_FIRES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ptt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [ptt_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [ptt_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   output logic                               rsp_tlast,
   output ptt_pkg::ptt_mem_req_type           mem_req,
   input  ptt_pkg::ptt_entry_type             rd_data,
   input  logic                               rd_valid
);
   import ptt_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [BUDGET_W-1:0]  budget_ff, budget_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W-1:0]    due_ff, due_in;
   logic                 active_ff, active_in;
   logic                 pend_valid_ff, pend_valid_in;
   ptt_result_type       pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   ptt_result_type       out_ff, out_in;

   logic [ID_W-1:0]      in_id;
   logic [TIME_W-1:0]    in_period;
   logic                 in_notify;
   logic [TIME_W-1:0]    in_now;
   req_kind_type         in_kind;
   logic                 id_ok;
   logic                 o_free;
   logic                 can_push;
   logic                 hit;
   logic                 push;
   logic                 flush;
   ptt_result_type       push_res;

   // unpack the request item
   assign in_id     = req_tdata[7:0];
   assign in_period = req_tdata[39:8];
   assign in_notify = req_tdata[40];
   assign in_now    = req_tdata[72:41];
   assign in_kind   = req_kind_type'(req_tuser);
   assign id_ok     = {1'b0, in_id} < (ID_W + 1)'(NUM_TIMERS);

   // output register frees this cycle, pending slot can take a new result
   assign o_free   = !out_valid_ff || rsp_tready;
   assign can_push = !pend_valid_ff || o_free;
   assign hit      = active_ff && (budget_ff != '0) && (now_ff >= due_ff);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      budget_in     = budget_ff;
      now_in        = now_ff;
      due_in        = due_ff;
      active_in     = active_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      mem_req       = '0;
      req_tready    = 1'b0;
      push          = 1'b0;
      flush         = 1'b0;
      push_res      = '0;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (in_kind)
                  REQ_TICK: begin
                     now_in    = in_now;
                     idx_in    = '0;
                     budget_in = BUDGET_W'(MAX_FIRES);
                     state_in  = ST_READ;
                  end
                  REQ_SET, REQ_KILL: begin
                     if (id_ok) begin
                        mem_req.wr_addr        = in_id;
                        mem_req.wr_data.period = in_period;
                        mem_req.wr_data.start  = in_now;
                        mem_req.wr_data.due    = in_now + in_period;
                        mem_req.wr_data.notify = in_notify;
                        if (in_kind == REQ_SET) begin
                           mem_req.wr_en     = 1'b1;
                           mem_req.set_valid = 1'b1;
                        end else begin
                           mem_req.kill_en = 1'b1;
                        end
                     end
                     push          = 1'b1;
                     push_res.kind = id_ok ? KIND_ACK : KIND_ERR;
                     push_res.id   = in_id;
                     state_in      = ST_FLUSH;
                  end
                  REQ_CLEAR: begin
                     mem_req.clear_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // issue the entry read
         ST_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ID_W'(idx_ff);
            state_in        = ST_LOAD;
         end

         // registered read data is here
         ST_LOAD: begin
            due_in    = rd_data.due;
            active_in = rd_valid && (rd_data.period != '0);
            state_in  = ST_LOOP;
         end

         // consume one period a cycle unless a fire waits for a free result slot, then write the due time back
         ST_LOOP: begin
            if (hit) begin
               if (!rd_data.notify || can_push) begin
                  if (rd_data.notify) begin
                     push             = 1'b1;
                     push_res.kind    = KIND_FIRE;
                     push_res.id      = ID_W'(idx_ff);
                     push_res.elapsed = now_ff - rd_data.start;
                  end
                  due_in    = due_ff + rd_data.period;
                  budget_in = budget_ff - BUDGET_W'(1);
               end
            end else begin
               if (active_ff) begin
                  mem_req.wr_en          = 1'b1;
                  mem_req.wr_addr        = ID_W'(idx_ff);
                  mem_req.wr_data.period = rd_data.period;
                  mem_req.wr_data.start  = rd_data.start;
                  mem_req.wr_data.due    = due_ff;
                  mem_req.wr_data.notify = rd_data.notify;
               end
               if ((idx_ff == IDX_W'(NUM_TIMERS - 1)) || (budget_ff == '0)) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end

         // hand the held result over, marked as the last of the item
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (o_free) begin
               flush    = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // one result is held back so the last one can be marked
      if (push) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            out_in.last  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = push_res;
      end else if (flush) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         out_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      budget_ff <= budget_in;
      now_ff    <= now_in;
      due_ff    <= due_in;
      active_ff <= active_in;
      pend_ff   <= pend_in;
      out_ff    <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.elapsed, out_ff.id};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

endmodule

`default_nettype wire

// ===== hw/rtl/ptt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptt_checker #(
   parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [ptt_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ptt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [ptt_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input logic                            rsp_tlast
);
   import ptt_pkg::*;

   logic req_fire;
   logic req_single;

   assign req_fire   = req_tvalid && req_tready;
   assign req_single = (req_tuser == REQ_SET) || (req_tuser == REQ_KILL);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // acknowledgements and errors are single items with zero elapsed time
   a_ack_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_FIRE) |-> rsp_tlast && (rsp_tdata[39:8] == '0))
      else $error("ack or error item malformed");

   // fires name a timer that exists
   a_fire_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_FIRE) |->
         ({1'b0, rsp_tdata[7:0]} < (ID_W + 1)'(NUM_TIMERS)))
      else $error("fire item names a timer out of range");

   // set or kill keeps the request side busy while its result goes out
   a_single_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_single |=> !req_tready)
      else $error("request taken while ack still held");

   // no result kind beyond error
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_FIRE) || (rsp_tuser == KIND_ACK) ||
                     (rsp_tuser == KIND_ERR))
      else $error("result kind out of range");

endmodule

bind periodic_timer_table ptt_checker #(
   .NUM_TIMERS (NUM_TIMERS)
) u_ptt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/sv/periodic_timer_table_test.sv =====
`timescale 1ns / 1ps

module periodic_timer_table_test;
   import ptt_pkg::*;

   localparam int TIMER_COUNT    = NUM_TIMERS_DEF;
   localparam int FIRE_BUDGET    = MAX_FIRES_DEF;
   // worst-case tick bound from the read/load/write-back per entry and the consumed periods
   localparam int TICK_CYCLES    = 2 + 3 * TIMER_COUNT + FIRE_BUDGET;
   localparam int DRAIN_HOLDOFF  = TICK_CYCLES + 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 154;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   // shadow copy of the timer table
   logic [TIME_W-1:0] period_tab [TIMER_COUNT];
   logic [TIME_W-1:0] start_tab  [TIMER_COUNT];
   logic [TIME_W-1:0] due_tab    [TIMER_COUNT];
   logic              notify_tab [TIMER_COUNT];

   ptt_result_type expected_events [$];
   int             mismatch_count = 0;
   int             quiet_cycles   = 0;
   int             rsp_stall_left = 0;
   bit             steady_flow    = 1'b0;
   logic [TIME_W-1:0] sim_now;

   periodic_timer_table #(
      .NUM_TIMERS(TIMER_COUNT),
      .MAX_FIRES (FIRE_BUDGET)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow) return 0;
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // expected results of one accepted item; updates the shadow table
   function automatic void predict_timer_events(req_kind_type kind, logic [ID_W-1:0] id,
                                                logic [TIME_W-1:0] period, logic notify,
                                                logic [TIME_W-1:0] now);
      ptt_result_type held;
      ptt_result_type res;
      bit             have_held;
      int             budget;
      have_held = 1'b0;
      held      = '0;
      case (kind)
         REQ_TICK: begin
            budget = FIRE_BUDGET;
            for (int i = 0; i < TIMER_COUNT && budget > 0; i++) begin
               if (period_tab[i] != '0) begin
                  while (budget > 0 && now >= due_tab[i]) begin
                     if (notify_tab[i]) begin
                        if (have_held) expected_events.push_back(held);
                        held.kind    = KIND_FIRE;
                        held.id      = ID_W'(i);
                        held.elapsed = now - start_tab[i];
                        held.last    = 1'b0;
                        have_held    = 1'b1;
                     end
                     due_tab[i] = due_tab[i] + period_tab[i];
                     budget--;
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               expected_events.push_back(held);
            end
         end
         REQ_SET, REQ_KILL: begin
            res.id      = id;
            res.elapsed = '0;
            res.last    = 1'b1;
            if (id >= TIMER_COUNT) begin
               res.kind = KIND_ERR;
            end else begin
               res.kind = KIND_ACK;
               if (kind == REQ_SET) begin
                  period_tab[id] = period;
                  start_tab[id]  = now;
                  due_tab[id]    = now + period;
                  notify_tab[id] = notify;
               end else begin
                  period_tab[id] = '0;
                  notify_tab[id] = 1'b0;
               end
            end
            expected_events.push_back(res);
         end
         default: begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
               period_tab[i] = '0;
               start_tab[i]  = '0;
               due_tab[i]    = '0;
               notify_tab[i] = 1'b0;
            end
         end
      endcase
   endfunction

   // send one item; valid stays high afterwards so back-to-back items need no toggle
   task automatic send_request(req_kind_type kind, logic [ID_W-1:0] id,
                               logic [TIME_W-1:0] period, logic notify,
                               logic [TIME_W-1:0] now);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, now, notify, period, id};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      predict_timer_events(kind, id, period, notify, now);
   endtask

   // sender holds off until every expected result is in and the block has settled
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_HOLDOFF) @(posedge clock);
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady_flow && $urandom_range(0, 3) == 0) rsp_stall_left <= idle_gap();
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      ptt_result_type got;
      ptt_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind    = rsp_kind_type'(rsp_tuser);
         got.id      = rsp_tdata[7:0];
         got.elapsed = rsp_tdata[39:8];
         got.last    = rsp_tlast;
         if (expected_events.size() == 0) begin
            $error("unexpected result item: kind %0d id %0d elapsed %0h last %0b",
                   got.kind, got.id, got.elapsed, got.last);
            mismatch_count++;
         end else begin
            want = expected_events.pop_front();
            if (got.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, got.kind);
               mismatch_count++;
            end
            if (got.id !== want.id) begin
               $error("fired_id: expected %0d, got %0d", want.id, got.id);
               mismatch_count++;
            end
            if (got.elapsed !== want.elapsed) begin
               $error("elapsed_ms: expected %0h, got %0h", want.elapsed, got.elapsed);
               mismatch_count++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, got.last);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("periodic_timer_table regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // out-of-range ids, zero period
   task automatic test_request_errors();
      send_request(REQ_SET, 8'd16, 32'd5, 1'b1, 32'd0);
      send_request(REQ_SET, 8'd255, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_request(REQ_KILL, 8'd16, 32'd0, 1'b0, 32'd0);
      send_request(REQ_KILL, 8'd255, 32'd0, 1'b1, 32'd0);
      send_request(REQ_SET, 8'd3, 32'd0, 1'b1, 32'd10);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'd100);
      send_request(REQ_KILL, 8'd3, 32'd0, 1'b0, 32'd0);
   endtask

   // catch-up on a notifying timer, budget cap and carry-over, clear
   task automatic test_fire_catchup();
      send_request(REQ_SET, 8'd0, 32'd1, 1'b1, 32'd0);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'd0);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'd5);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
      send_request(REQ_CLEAR, 8'd0, 32'd0, 1'b0, 32'd0);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
   endtask

   // silent periods spend the budget too
   task automatic test_silent_budget();
      send_request(REQ_SET, 8'd0, 32'd1, 1'b0, 32'd0);
      send_request(REQ_SET, 8'd1, 32'd7, 1'b1, 32'd0);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'd100);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'd100);
      send_request(REQ_KILL, 8'd0, 32'd0, 1'b0, 32'd0);
      send_request(REQ_KILL, 8'd1, 32'd0, 1'b0, 32'd0);
   endtask

   // due time and elapsed wrap modulo 2^32
   task automatic test_wraparound();
      send_request(REQ_SET, 8'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFE);
      send_request(REQ_CLEAR, 8'd0, 32'd0, 1'b0, 32'd0);
      send_request(REQ_SET, 8'd1, 32'h20, 1'b1, 32'hFFFF_FFF0);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'h8);
      send_request(REQ_TICK, 8'd0, 32'd0, 1'b0, 32'h18);
   endtask

   // random timeline: mostly sets and advancing ticks, some kills, clears and noise
   task automatic test_random_timers();
      int               r;
      logic [ID_W-1:0]  id;
      logic [TIME_W-1:0] period;
      sim_now = $urandom_range(0, 1000);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady_flow = (n >= 60 && n < 90);
         if (n == 100) wait_for_drain();
         if (n == 120) sim_now = 32'hFFFF_FF80;
         r  = $urandom_range(0, 99);
         id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(16, 255))
                                          : ID_W'($urandom_range(0, TIMER_COUNT - 1));
         if (r < 44) begin
            sim_now = sim_now + $urandom_range(0, 24);
            if ($urandom_range(0, 39) == 0) sim_now = sim_now + $urandom;
            send_request(REQ_TICK, ID_W'($urandom), $urandom, 1'($urandom), sim_now);
         end else if (r < 76) begin
            case ($urandom_range(0, 9))
               0:       period = '0;
               1, 2:    period = $urandom;
               default: period = $urandom_range(1, 40);
            endcase
            send_request(REQ_SET, id, period, ($urandom_range(0, 3) != 0), sim_now);
         end else if (r < 88) begin
            send_request(REQ_KILL, id, $urandom, 1'($urandom), $urandom);
         end else if (r < 91) begin
            send_request(REQ_CLEAR, ID_W'($urandom), $urandom, 1'($urandom), $urandom);
         end else begin
            send_request(req_kind_type'($urandom_range(0, 3)), ID_W'($urandom), $urandom,
                         1'($urandom), $urandom);
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
         period_tab[i] = '0;
         start_tab[i]  = '0;
         due_tab[i]    = '0;
         notify_tab[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_request_errors();
      test_fire_catchup();
      test_silent_budget();
      test_wraparound();
      test_random_timers();
      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("periodic_timer_table regression: pass");
      end else begin
         $display("periodic_timer_table regression: fail");
      end
      $finish;
   end

endmodule
